[rtl/ps2mtc_pkg.sv]
// Shared types, constants and helper functions for the PS/2 mouse text-cursor tracker.
`default_nettype none

package ps2mtc_pkg;

   // Coordinate width of the cursor and anchor; limits are capped to its range
   localparam int unsigned COORD_BITS = 8;
   localparam int unsigned COORD_MASK = (2 ** COORD_BITS) - 1;
   localparam int unsigned LIM_BITS   = (COORD_BITS > 8) ? COORD_BITS : 8;
   localparam int unsigned SUM_BITS   = COORD_BITS + 2;

   typedef logic [COORD_BITS-1:0]      coord_type;
   typedef logic [7:0]                 byte_type;
   typedef logic [2:0]                 step_type;
   typedef logic signed [SUM_BITS-1:0] sum_type;

   // Position of the next byte inside a packet
   typedef enum logic [1:0] {
      IDX_STATUS = 2'd0,
      IDX_DX     = 2'd1,
      IDX_DY     = 2'd2
   } byte_idx_type;

   // Configuration register indexes
   localparam logic [1:0] CSR_COL_MAX = 2'd0;
   localparam logic [1:0] CSR_ROW_MAX = 2'd1;

   // Status byte bits
   localparam byte_type SIGN_X   = 8'h10;
   localparam byte_type SIGN_Y   = 8'h20;
   localparam byte_type LEFT_BIT = 8'h01;

   // Magnitude band edges
   localparam byte_type SMALL_LIMIT = 8'd10;
   localparam byte_type MID_LIMIT   = 8'd25;
   localparam byte_type BIG_LIMIT   = 8'd127;

   // Reset values
   localparam byte_type  COL_MAX_RESET = 8'd79;
   localparam byte_type  ROW_MAX_RESET = 8'd24;
   localparam coord_type POS_RESET     = COORD_BITS'(20);

   // Step sizes per axis
   localparam step_type Y_STEP1 = 3'd1;
   localparam step_type Y_STEP2 = 3'd2;
   localparam step_type Y_STEP3 = 3'd3;
   localparam step_type X_STEP1 = 3'd1;
   localparam step_type X_STEP2 = 3'd4;
   localparam step_type X_STEP3 = 3'd7;

   // Turn a sign-and-magnitude delta into a step size
   function automatic step_type step_of(byte_type raw, logic neg,
                                        step_type s1, step_type s2, step_type s3);
      byte_type mag;
      step_type res;
      mag = neg ? byte_type'(8'd0 - raw) : raw;
      res = 3'd0;
      if (mag inside {[8'd2 : SMALL_LIMIT]}) begin
         res = s1;
      end else if (mag inside {[SMALL_LIMIT + 8'd1 : MID_LIMIT]}) begin
         res = s2;
      end else if (mag inside {[MID_LIMIT + 8'd1 : BIG_LIMIT]}) begin
         res = s3;
      end
      return res;
   endfunction

   // Limit a moved coordinate to 0..limit, limit itself capped to the coordinate range
   function automatic coord_type clamp_axis(sum_type v, byte_type limit);
      logic [LIM_BITS-1:0] lim_w;
      sum_type             lim_s;
      sum_type             res;
      lim_w = LIM_BITS'(limit);
      if (lim_w > LIM_BITS'(COORD_MASK)) begin
         lim_w = LIM_BITS'(COORD_MASK);
      end
      lim_s = sum_type'({2'b00, coord_type'(lim_w)});
      res   = v;
      if (res >= lim_s) begin
         res = lim_s;
      end
      if (res <= sum_type'(0)) begin
         res = sum_type'(0);
      end
      return coord_type'(res[COORD_BITS-1:0]);
   endfunction

endpackage

`default_nettype wire

[rtl/ps2_mouse_text_cursor_tracker_unit.sv]
// Top level of the PS/2 mouse text-cursor tracker: packet assembly, cursor move and result register.
// A byte transfer lands in the input register; a packet's third byte loads the result register
// once that register is free, and rsp_tvalid is driven from it. Throughput: one byte per cycle while
// the result register can take a result, set by the input register feeding the result register through
// one pass of move and clamp logic; the first two bytes of a packet give no result.
// Reset (synchronous, active high): limits 79 and 24, cursor at column 20 row 20,
// anchor at 0,0, packet assembly at the status byte, both registers empty.
`default_nettype none

module ps2_mouse_text_cursor_tracker_unit (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input byte channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,   // [7:0] data_byte
   // result channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [4*ps2mtc_pkg::COORD_BITS+7:0] rsp_tdata,
   // fields from bit 0 up: cursor_col, cursor_row, restore_col, restore_row,
   // left_pressed, zero fill to whole bytes
   // configuration write channel
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [1:0]            csr_index,
   input  wire logic [7:0]            csr_data
);
   import ps2mtc_pkg::*;

   localparam int unsigned OUT_BITS  = 4 * COORD_BITS + 8;
   localparam int unsigned FILL_BITS = OUT_BITS - 4 * COORD_BITS - 1;

   // Configuration
   byte_type     col_max_ff, row_max_ff;
   // Input register
   logic         in_valid_ff;
   byte_type     in_byte_ff;
   // Packet and cursor state
   byte_idx_type idx_ff, idx_in;
   byte_type     status_ff, status_in;
   byte_type     dx_ff, dx_in;
   coord_type    pos_col_ff, pos_col_in;
   coord_type    pos_row_ff, pos_row_in;
   coord_type    anchor_col_ff, anchor_col_in;
   coord_type    anchor_row_ff, anchor_row_in;
   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic      is_dy, out_free, in_go;
   step_type  dx_step, dy_step;
   sum_type   ncol, nrow;
   coord_type new_col, new_row, rest_col, rest_row;
   logic      left;

   // Handshakes
   assign csr_ready  = 1'b1;
   assign is_dy      = in_valid_ff && (idx_ff == IDX_DY);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign in_go      = in_valid_ff && (!is_dy || out_free);
   assign req_tready = !in_valid_ff || in_go;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Move and clamp for the packet completed by the held byte
   always_comb begin
      left    = status_ff[0];
      dy_step = step_of(in_byte_ff, (status_ff & SIGN_Y) != 8'd0, Y_STEP1, Y_STEP2, Y_STEP3);
      dx_step = step_of(dx_ff, (status_ff & SIGN_X) != 8'd0, X_STEP1, X_STEP2, X_STEP3);
      if ((status_ff & SIGN_Y) != 8'd0) begin
         nrow = sum_type'({2'b00, pos_row_ff}) + sum_type'({1'b0, dy_step});
      end else begin
         nrow = sum_type'({2'b00, pos_row_ff}) - sum_type'({1'b0, dy_step});
      end
      if ((status_ff & SIGN_X) != 8'd0) begin
         ncol = sum_type'({2'b00, pos_col_ff}) - sum_type'({1'b0, dx_step});
      end else begin
         ncol = sum_type'({2'b00, pos_col_ff}) + sum_type'({1'b0, dx_step});
      end
      new_col  = clamp_axis(ncol, col_max_ff);
      new_row  = clamp_axis(nrow, row_max_ff);
      rest_col = left ? anchor_col_ff : pos_col_ff;
      rest_row = left ? anchor_row_ff : pos_row_ff;
   end

   // Next state of packet assembly and cursor
   always_comb begin
      idx_in        = idx_ff;
      status_in     = status_ff;
      dx_in         = dx_ff;
      pos_col_in    = pos_col_ff;
      pos_row_in    = pos_row_ff;
      anchor_col_in = anchor_col_ff;
      anchor_row_in = anchor_row_ff;
      if (in_go) begin
         case (idx_ff)
            IDX_DX: begin
               dx_in  = in_byte_ff;
               idx_in = IDX_DY;
            end
            IDX_DY: begin
               idx_in     = IDX_STATUS;
               pos_col_in = new_col;
               pos_row_in = new_row;
               if (left) begin
                  anchor_col_in = pos_col_ff;
                  anchor_row_in = pos_row_ff;
               end
            end
            default: begin
               status_in = in_byte_ff;
               idx_in    = IDX_DX;
            end
         endcase
      end
   end

   // Next result register contents
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (in_go && is_dy) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {FILL_BITS'(0), left, rest_row, rest_col, new_row, new_col};
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         col_max_ff    <= COL_MAX_RESET;
         row_max_ff    <= ROW_MAX_RESET;
         in_valid_ff   <= 1'b0;
         idx_ff        <= IDX_STATUS;
         status_ff     <= 8'd0;
         dx_ff         <= 8'd0;
         pos_col_ff    <= POS_RESET;
         pos_row_ff    <= POS_RESET;
         anchor_col_ff <= '0;
         anchor_row_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_COL_MAX: col_max_ff <= csr_data;
               CSR_ROW_MAX: row_max_ff <= csr_data;
               default: ;
            endcase
         end
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         idx_ff        <= idx_in;
         status_ff     <= status_in;
         dx_ff         <= dx_in;
         pos_col_ff    <= pos_col_in;
         pos_row_ff    <= pos_row_in;
         anchor_col_ff <= anchor_col_in;
         anchor_row_ff <= anchor_row_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers: hold the input byte and result until moved on
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the PS/2 mouse text-cursor tracker: packet stimulus and scoreboard.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ps2mtc_pkg::*;

   localparam int CB          = COORD_BITS;
   localparam int RSP_W       = 4 * CB + 8;
   localparam int SETTLE      = 6;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int PACKETS     = 90;

   // One cursor update as the block reports it
   typedef struct packed {
      coord_type cursor_col;
      coord_type cursor_row;
      coord_type restore_col;
      coord_type restore_row;
      logic      left_pressed;
   } cursor_move_type;

   // Tracks packet assembly and cursor state, queues the expected moves
   class cursor_scoreboard;
      byte_type        col_lim;
      byte_type        row_lim;
      byte_idx_type    slot;
      byte_type        status_byte;
      byte_type        dx_byte;
      coord_type       col;
      coord_type       row;
      coord_type       anc_col;
      coord_type       anc_row;
      cursor_move_type moves[$];
      int              errors;
      int              checked;

      function new();
         col_lim     = COL_MAX_RESET;
         row_lim     = ROW_MAX_RESET;
         slot        = IDX_STATUS;
         status_byte = '0;
         dx_byte     = '0;
         col         = POS_RESET;
         row         = POS_RESET;
         anc_col     = '0;
         anc_row     = '0;
         errors      = 0;
         checked     = 0;
      endfunction

      function void set_limit(logic [1:0] idx, byte_type v);
         if (idx == CSR_COL_MAX) begin
            col_lim = v;
         end else if (idx == CSR_ROW_MAX) begin
            row_lim = v;
         end
      endfunction

      // step for a sign-and-magnitude delta; magnitudes outside 2..127 give none
      function int step_for(byte_type raw, logic neg, int s1, int s2, int s3);
         byte_type mag;
         mag = neg ? byte_type'(8'd0 - raw) : raw;
         if (mag >= 8'd2 && mag <= SMALL_LIMIT) return s1;
         if (mag > SMALL_LIMIT && mag <= MID_LIMIT) return s2;
         if (mag > MID_LIMIT && mag <= BIG_LIMIT) return s3;
         return 0;
      endfunction

      // upper limit first, then floor at zero
      function coord_type limit_axis(int v, byte_type lim);
         int r;
         r = v;
         if (r >= int'(lim)) r = int'(lim);
         if (r <= 0) r = 0;
         return coord_type'(r);
      endfunction

      function void note_byte(byte_type b);
         cursor_move_type m;
         int              ncol;
         int              nrow;
         case (slot)
            IDX_DX: begin
               dx_byte = b;
               slot    = IDX_DY;
            end
            IDX_DY: begin
               slot           = IDX_STATUS;
               m.left_pressed = status_byte[0];
               // held left button: restore the old anchor, anchor follows the old cursor
               if ((status_byte & LEFT_BIT) != 0) begin
                  m.restore_col = anc_col;
                  m.restore_row = anc_row;
                  anc_col       = col;
                  anc_row       = row;
               end else begin
                  m.restore_col = col;
                  m.restore_row = row;
               end
               // Y is inverted: negative delta moves the row down the screen
               if ((status_byte & SIGN_Y) != 0) begin
                  nrow = int'(row) + step_for(b, 1'b1, 1, 2, 3);
               end else begin
                  nrow = int'(row) - step_for(b, 1'b0, 1, 2, 3);
               end
               if ((status_byte & SIGN_X) != 0) begin
                  ncol = int'(col) - step_for(dx_byte, 1'b1, 1, 4, 7);
               end else begin
                  ncol = int'(col) + step_for(dx_byte, 1'b0, 1, 4, 7);
               end
               col          = limit_axis(ncol, col_lim);
               row          = limit_axis(nrow, row_lim);
               m.cursor_col = col;
               m.cursor_row = row;
               moves.push_back(m);
            end
            default: begin
               status_byte = b;
               slot        = IDX_DX;
            end
         endcase
      endfunction

      function void check_field(string name, int exp_v, int act_v);
         if (exp_v != act_v) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_result(logic [RSP_W-1:0] word);
         cursor_move_type e;
         if (moves.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual 0x%0h", $time, word);
            errors++;
            return;
         end
         e = moves.pop_front();
         checked++;
         check_field("cursor_col", e.cursor_col, word[CB-1:0]);
         check_field("cursor_row", e.cursor_row, word[2*CB-1:CB]);
         check_field("restore_col", e.restore_col, word[3*CB-1:2*CB]);
         check_field("restore_row", e.restore_row, word[4*CB-1:3*CB]);
         check_field("left_pressed", e.left_pressed, word[4*CB]);
      endfunction

      function int pending();
         return moves.size();
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [7:0]       req_tdata;   // [7:0] data_byte
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;   // cursor_col, cursor_row, restore_col, restore_row, left_pressed
   logic             csr_valid;
   logic             csr_ready;
   logic [1:0]       csr_index;
   logic [7:0]       csr_data;

   cursor_scoreboard board;
   int               send_pct;
   int               recv_pct;
   int               hold_asked;
   int               hold_taken;
   int               hold_left;
   int               cycles;
   int               bytes_sent;
   int               settings;

   ps2_mouse_text_cursor_tracker_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Bound the run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, board.pending());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Drive the receiver: random stalls plus an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_asked != hold_taken) begin
            hold_taken = hold_asked;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_pct);
         end
      end
   end

   // Observe transfers on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
         if (req_tvalid && req_tready) begin
            board.note_byte(req_tdata);
            bytes_sent++;
         end
      end
   end

   // Idle cycle by cycle with the sender's idle share, then offer the byte until taken
   task automatic send_byte(input byte_type b);
      while ($urandom_range(0, 99) < send_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_packet(input byte_type st, input byte_type dx, input byte_type dy);
      send_byte(st);
      send_byte(dx);
      send_byte(dy);
   endtask

   // Stop offering bytes, wait for every result, then let the pipeline settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input byte_type v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      board.set_limit(idx, v);
   endtask

   // Delta byte biased towards the band edges, mostly encoded to match its sign bit, sometimes random
   function automatic byte_type pick_delta(logic neg);
      byte_type mag;
      byte_type edges[6];
      edges = '{8'd2, 8'd10, 8'd11, 8'd25, 8'd26, 8'd127};
      case ($urandom_range(0, 9))
         0:       mag = byte_type'($urandom_range(0, 1));
         1:       mag = byte_type'($urandom_range(2, 10));
         2:       mag = byte_type'($urandom_range(11, 25));
         3, 4, 5: mag = byte_type'($urandom_range(26, 127));
         6:       mag = 8'd128;
         7:       mag = edges[$urandom_range(0, 5)];
         default: return byte_type'($urandom_range(0, 255));
      endcase
      return neg ? byte_type'(8'd0 - mag) : mag;
   endfunction

   // Mostly well-formed packets drifting one way, some fully random ones
   task automatic random_packets(input int count);
      byte_type st;
      byte_type drift;
      drift = byte_type'($urandom_range(0, 3)) << 4;
      for (int p = 0; p < count; p++) begin
         if (p == count / 2) wait_idle();
         if ($urandom_range(0, 9) == 0) begin
            send_packet(byte_type'($urandom), byte_type'($urandom), byte_type'($urandom));
         end else begin
            st = byte_type'($urandom_range(0, 255));
            if ($urandom_range(0, 9) < 6) st = (st & ~(SIGN_X | SIGN_Y)) | drift;
            send_packet(st, pick_delta(st[4]), pick_delta(st[5]));
         end
      end
   endtask

   task automatic set_limits(input byte_type c, input byte_type r);
      write_reg(CSR_COL_MAX, c);
      write_reg(CSR_ROW_MAX, r);
      settings++;
   endtask

   initial begin
      byte_type col_set[5];
      byte_type row_set[5];
      col_set    = '{8'd255, 8'd1, 8'd0, 8'd200, 8'd6};
      row_set    = '{8'd255, 8'd1, 8'd0, 8'd3, 8'd255};
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = CSR_COL_MAX;
      csr_data   = '0;
      hold_asked = 0;
      hold_taken = 0;
      hold_left  = 0;
      cycles     = 0;
      bytes_sent = 0;
      settings   = 1;
      send_pct   = 33;
      recv_pct   = 72;
      board      = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed packets under the reset limits: each magnitude band edge, some with both signs
      send_packet(8'h00, 8'h00, 8'h00);
      send_packet(8'h00, 8'h01, 8'h01);
      send_packet(8'h00, 8'h02, 8'h02);
      send_packet(8'h30, 8'hF6, 8'hF5);
      send_packet(8'h01, 8'h0B, 8'h19);
      send_packet(8'h31, 8'hE7, 8'hE6);
      send_packet(8'h00, 8'h7F, 8'h1A);
      send_packet(8'hFF, 8'h80, 8'h00);
      send_packet(8'h00, 8'h80, 8'hFF);
      wait_idle();

      // Random phases, one limit setting each
      for (int ph = 0; ph < 5; ph++) begin
         if (ph == 1) begin
            send_pct = 72;
            recv_pct = 33;
         end else if (ph == 3) begin
            send_pct = 0;
            recv_pct = 0;
         end
         set_limits(col_set[ph], row_set[ph]);
         // hold the receiver off while the sender keeps offering bytes
         if (ph == 4) hold_asked++;
         random_packets(PACKETS);
         wait_idle();
      end

      repeat (SETTLE) @(posedge clock);
      $display("Sent %0d mouse bytes, checked %0d cursor updates", bytes_sent, board.checked);
      $display("Ran %0d limit settings, extremes 0, 1 and 255 included", settings);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0t: %0d mismatches, %0d results never arrived",
                  $time, board.errors, board.pending());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
